// ===== hdl/bvm_pkg.sv =====
// ---------------------------------------------------------------------------
// bvm_pkg: shared types and constants of the battery voltage monitor
// Widths, reset values, register indexes and the structs between the parts.
// ---------------------------------------------------------------------------
package bvm_pkg;

  localparam int WINDOW_SLOTS = 4;

  localparam int SAMPLE_W  = 12;
  localparam int MV_W      = 16;
  localparam int KOHM_W    = 10;
  localparam int PCT_W     = 7;
  localparam int CFG_IDX_W = 3;

  localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
  localparam int SUM_W      = $clog2(WINDOW_SLOTS * SAMPLE_MAX + 1);
  localparam int COUNT_W    = $clog2(WINDOW_SLOTS + 1);
  localparam int SLOT_W     = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
  localparam int RATIO_W    = KOHM_W + 1;

  // shared divider: widest dividend is sample * ratio or span * 100
  localparam int DIV_N_W   = SAMPLE_W + RATIO_W;
  localparam int DIV_D_W   = MV_W;
  localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

  localparam logic [MV_W-1:0]  EARLY_LIMIT_MV = 16'd1000;
  localparam logic [MV_W-1:0]  MV_MAX         = 16'hFFFF;
  localparam logic [PCT_W-1:0] PCT_SCALE      = 7'd100;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_DIV_TOP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIV_BOTTOM = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PLAUS_MIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PLAUS_MAX  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CRITICAL   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FULL       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY      = 3'd6;

  // register reset values
  localparam logic [KOHM_W-1:0] RST_DIV_TOP    = 10'd100;
  localparam logic [KOHM_W-1:0] RST_DIV_BOTTOM = 10'd100;
  localparam logic [MV_W-1:0]   RST_PLAUS_MIN  = 16'd2500;
  localparam logic [MV_W-1:0]   RST_PLAUS_MAX  = 16'd4500;
  localparam logic [MV_W-1:0]   RST_CRITICAL   = 16'd3300;
  localparam logic [MV_W-1:0]   RST_FULL       = 16'd4200;
  localparam logic [MV_W-1:0]   RST_EMPTY      = 16'd3500;

  typedef struct packed {
    logic [KOHM_W-1:0] div_top;
    logic [KOHM_W-1:0] div_bottom;
    logic [MV_W-1:0]   plaus_min;
    logic [MV_W-1:0]   plaus_max;
    logic [MV_W-1:0]   critical_mv;
    logic [MV_W-1:0]   full_mv;
    logic [MV_W-1:0]   empty_mv;
  } cfg_t;

  // one classified slot, passed from front to back
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                ok;
    logic                last;
    logic [SUM_W-1:0]    sum;
    logic [COUNT_W-1:0]  count;
  } cmd_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_N_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== hdl/bvm_sample_if.sv =====
// ---------------------------------------------------------------------------
// bvm_sample_if: sample request channel
// One sampling slot: reading in millivolts and the read-ok flag.
// ---------------------------------------------------------------------------
interface bvm_sample_if;
  logic                         valid;
  logic                         ready;
  logic [bvm_pkg::SAMPLE_W-1:0] sample_mv;
  logic                         sample_ok;

  modport source (output valid, output sample_mv, output sample_ok, input ready);
  modport sink   (input valid, input sample_mv, input sample_ok, output ready);
endinterface

// ===== hdl/bvm_result_if.sv =====
// ---------------------------------------------------------------------------
// bvm_result_if: result request channel
// Stored voltage, charge percent and window status of one slot.
// ---------------------------------------------------------------------------
interface bvm_result_if;
  logic                      valid;
  logic                      ready;
  logic [bvm_pkg::MV_W-1:0]  battery_mv;
  logic [bvm_pkg::PCT_W-1:0] percent;
  logic                      window_done;
  logic                      window_empty;
  logic                      critical;
  logic                      scaling_suspect;

  modport source (output valid, output battery_mv, output percent, output window_done,
                  output window_empty, output critical, output scaling_suspect,
                  input ready);
  modport sink   (input valid, input battery_mv, input percent, input window_done,
                  input window_empty, input critical, input scaling_suspect,
                  output ready);
endinterface

// ===== hdl/bvm_cfg_if.sv =====
// ---------------------------------------------------------------------------
// bvm_cfg_if: configuration write channel
// Register index and write data; one register per request.
// ---------------------------------------------------------------------------
interface bvm_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bvm_pkg::CFG_IDX_W-1:0] index;
  logic [bvm_pkg::MV_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/bvm_front.sv =====
// ---------------------------------------------------------------------------
// bvm_front: sample intake
// Accepts slots, accumulates the window sum and count, marks the last slot.
// ---------------------------------------------------------------------------
module bvm_front (
  input  logic            clk,
  input  logic            rst,
  bvm_sample_if.sink      samples,
  input  logic            full,
  output logic            push,
  output bvm_pkg::cmd_t   push_cmd
);

  logic [bvm_pkg::SUM_W-1:0]   sum;
  logic [bvm_pkg::COUNT_W-1:0] count;
  logic [bvm_pkg::SLOT_W-1:0]  slot;
  logic [bvm_pkg::SUM_W-1:0]   sum_next;
  logic [bvm_pkg::COUNT_W-1:0] count_next;
  logic                        last;

  assign samples.ready = !full;
  assign push          = samples.valid && !full;

  assign last       = (slot == bvm_pkg::SLOT_W'(bvm_pkg::WINDOW_SLOTS - 1));
  assign sum_next   = samples.sample_ok ? sum + bvm_pkg::SUM_W'(samples.sample_mv) : sum;
  assign count_next = count + bvm_pkg::COUNT_W'(samples.sample_ok);

  always_comb begin
    push_cmd.sample = samples.sample_mv;
    push_cmd.ok     = samples.sample_ok;
    push_cmd.last   = last;
    push_cmd.sum    = sum_next;
    push_cmd.count  = count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum   <= '0;
      count <= '0;
      slot  <= '0;
    end else if (push) begin
      if (last) begin
        sum   <= '0;
        count <= '0;
        slot  <= '0;
      end else begin
        sum   <= sum_next;
        count <= count_next;
        slot  <= slot + bvm_pkg::SLOT_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    int'(slot) < bvm_pkg::WINDOW_SLOTS)
    else $error("slot index past window end");
`endif

endmodule

// ===== hdl/bvm_queue.sv =====
// ---------------------------------------------------------------------------
// bvm_queue: two-entry command queue
// Decouples sample intake from the arithmetic sequencer.
// ---------------------------------------------------------------------------
module bvm_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bvm_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          full,
  output logic          empty,
  output bvm_pkg::cmd_t head
);

  bvm_pkg::cmd_t entries [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;

  assign full  = (fill == 2'd2);
  assign empty = (fill == 2'd0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("pop from empty queue");
`endif

endmodule

// ===== hdl/bvm_div.sv =====
// ---------------------------------------------------------------------------
// bvm_div: shared restoring divider
// One quotient bit per cycle; done pulses when the quotient is ready.
// ---------------------------------------------------------------------------
module bvm_div (
  input  logic              clk,
  input  logic              rst,
  input  bvm_pkg::div_req_t req,
  output bvm_pkg::div_rsp_t rsp
);

  logic [bvm_pkg::DIV_N_W-1:0]   dvd;
  logic [bvm_pkg::DIV_D_W-1:0]   divisor;
  logic [bvm_pkg::DIV_D_W-1:0]   rem;
  logic [bvm_pkg::DIV_CNT_W-1:0] cnt;
  logic                          busy;
  logic                          done;
  logic [bvm_pkg::DIV_D_W:0]     rem_sh;
  logic [bvm_pkg::DIV_D_W:0]     diff;

  assign rem_sh = {rem, dvd[bvm_pkg::DIV_N_W-1]};
  assign diff   = rem_sh - {1'b0, divisor};

  assign rsp.done     = done;
  assign rsp.quotient = dvd;

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd     <= req.dividend;
      divisor <= req.divisor;
      rem     <= '0;
    end else if (busy) begin
      if (!diff[bvm_pkg::DIV_D_W]) begin
        rem <= diff[bvm_pkg::DIV_D_W-1:0];
        dvd <= {dvd[bvm_pkg::DIV_N_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[bvm_pkg::DIV_D_W-1:0];
        dvd <= {dvd[bvm_pkg::DIV_N_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= bvm_pkg::DIV_CNT_W'(bvm_pkg::DIV_N_W);
      end else if (busy) begin
        cnt <= cnt - bvm_pkg::DIV_CNT_W'(1);
        if (cnt == bvm_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy)
    else $error("divider restarted while busy");
`endif

endmodule

// ===== hdl/bvm_back.sv =====
// ---------------------------------------------------------------------------
// bvm_back: arithmetic sequencer and result register
// Runs percent per slot; early update, window average and scaling check when due.
// ---------------------------------------------------------------------------
module bvm_back (
  input  logic              clk,
  input  logic              rst,
  input  bvm_pkg::cfg_t     cfg,
  input  logic              q_empty,
  input  bvm_pkg::cmd_t     head,
  output logic              pop,
  output bvm_pkg::div_req_t div_req,
  input  bvm_pkg::div_rsp_t div_rsp,
  bvm_result_if.source      results
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_EARLY = 12'b0000_0000_0010,
    S_WIN   = 12'b0000_0000_0100,
    S_AVG   = 12'b0000_0000_1000,
    S_MUL   = 12'b0000_0001_0000,
    S_SCALE = 12'b0000_0010_0000,
    S_SWAIT = 12'b0000_0100_0000,
    S_CRIT  = 12'b0000_1000_0000,
    S_PCT   = 12'b0001_0000_0000,
    S_PDIV  = 12'b0010_0000_0000,
    S_PWAIT = 12'b0100_0000_0000,
    S_OUT   = 12'b1000_0000_0000
  } state_t;

  state_t                        state;
  bvm_pkg::cmd_t                 cmd;
  logic [bvm_pkg::SAMPLE_W-1:0]  raw;
  logic                          from_win;
  logic [bvm_pkg::DIV_N_W-1:0]   prod;
  logic [bvm_pkg::MV_W-1:0]      stored;
  logic                          mismatch;
  logic                          crit;
  logic [bvm_pkg::PCT_W-1:0]     pct;
  logic                          out_valid;

  logic [bvm_pkg::RATIO_W-1:0]   ratio;
  logic [bvm_pkg::MV_W-1:0]      clamped;
  logic [bvm_pkg::MV_W-1:0]      span;
  logic                          in_range;
  logic [bvm_pkg::MV_W-1:0]      scaled_sat;
  logic                          win_avg;

  assign ratio   = bvm_pkg::RATIO_W'(cfg.div_top) + bvm_pkg::RATIO_W'(cfg.div_bottom);
  assign span    = cfg.full_mv - cfg.empty_mv;
  assign win_avg = cmd.last && (cmd.count != '0);

  always_comb begin
    if (stored > cfg.full_mv) begin
      clamped = cfg.full_mv;
    end else if (stored < cfg.empty_mv) begin
      clamped = cfg.empty_mv;
    end else begin
      clamped = stored;
    end
  end

  assign in_range = (div_rsp.quotient >= bvm_pkg::DIV_N_W'(cfg.plaus_min)) &&
                    (div_rsp.quotient <= bvm_pkg::DIV_N_W'(cfg.plaus_max));
  assign scaled_sat = (div_rsp.quotient > bvm_pkg::DIV_N_W'(bvm_pkg::MV_MAX)) ?
                      bvm_pkg::MV_MAX : div_rsp.quotient[bvm_pkg::MV_W-1:0];

  assign pop = (state == S_IDLE) && !q_empty && !out_valid;

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = prod;
    div_req.divisor  = bvm_pkg::DIV_D_W'(cfg.div_bottom);
    case (state)
      S_WIN: begin
        div_req.start    = win_avg;
        div_req.dividend = bvm_pkg::DIV_N_W'(cmd.sum);
        div_req.divisor  = bvm_pkg::DIV_D_W'(cmd.count);
      end
      S_SCALE: begin
        div_req.start = (cfg.div_bottom != '0);
      end
      S_PDIV: begin
        div_req.start   = 1'b1;
        div_req.divisor = span;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      stored    <= '0;
      mismatch  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && results.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pop) begin
            cmd   <= head;
            crit  <= 1'b0;
            state <= S_EARLY;
          end
        end
        S_EARLY: begin
          if (cmd.ok && stored <= bvm_pkg::EARLY_LIMIT_MV) begin
            raw      <= cmd.sample;
            from_win <= 1'b0;
            state    <= S_MUL;
          end else begin
            state <= S_WIN;
          end
        end
        S_WIN: begin
          state <= win_avg ? S_AVG : S_PCT;
        end
        S_AVG: begin
          if (div_rsp.done) begin
            raw      <= div_rsp.quotient[bvm_pkg::SAMPLE_W-1:0];
            from_win <= 1'b1;
            state    <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= bvm_pkg::DIV_N_W'(raw) * bvm_pkg::DIV_N_W'(ratio);
          state <= S_SCALE;
        end
        S_SCALE: begin
          if (cfg.div_bottom == '0) begin
            stored   <= bvm_pkg::MV_W'(raw);
            mismatch <= 1'b1;
            state    <= from_win ? S_CRIT : S_WIN;
          end else begin
            state <= S_SWAIT;
          end
        end
        S_SWAIT: begin
          if (div_rsp.done) begin
            if (in_range) begin
              stored <= scaled_sat;
            end else begin
              stored   <= bvm_pkg::MV_W'(raw);
              mismatch <= 1'b1;
            end
            state <= from_win ? S_CRIT : S_WIN;
          end
        end
        S_CRIT: begin
          crit  <= (stored < cfg.critical_mv);
          state <= S_PCT;
        end
        S_PCT: begin
          if (cfg.full_mv <= cfg.empty_mv) begin
            pct   <= '0;
            state <= S_OUT;
          end else begin
            prod  <= bvm_pkg::DIV_N_W'(clamped - cfg.empty_mv) *
                     bvm_pkg::DIV_N_W'(bvm_pkg::PCT_SCALE);
            state <= S_PDIV;
          end
        end
        S_PDIV: begin
          state <= S_PWAIT;
        end
        S_PWAIT: begin
          if (div_rsp.done) begin
            pct   <= div_rsp.quotient[bvm_pkg::PCT_W-1:0];
            state <= S_OUT;
          end
        end
        S_OUT: begin
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result register: loaded as the slot finishes, held until taken
  always_ff @(posedge clk) begin
    if (state == S_OUT) begin
      results.battery_mv      <= stored;
      results.percent         <= pct;
      results.window_done     <= cmd.last;
      results.window_empty    <= cmd.last && (cmd.count == '0);
      results.critical        <= crit;
      results.scaling_suspect <= mismatch;
    end
  end

  assign results.valid = out_valid;

`ifndef SYNTHESIS
  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> results.percent <= bvm_pkg::PCT_SCALE)
    else $error("percent above one hundred");

  a_mismatch_sticky: assert property (@(posedge clk) disable iff (rst)
    mismatch |=> mismatch)
    else $error("mismatch flag cleared");

  a_crit_only_window: assert property (@(posedge clk) disable iff (rst)
    out_valid && results.critical |-> results.window_done && !results.window_empty)
    else $error("critical outside a finished window");
`endif

endmodule

// ===== hdl/battery_voltage_monitor.sv =====
// ---------------------------------------------------------------------------
// battery_voltage_monitor: windowed battery voltage monitor
// Averages valid readings over a window of slots, scales them through the
// resistor divider, checks plausibility and reports voltage and percent.
// ---------------------------------------------------------------------------
//
//  channel   direction  handshake      request carries
//  samples   in         valid/ready    sample_mv, sample_ok
//  results   out        valid/ready    battery_mv, percent, window flags
//  cfg       in         valid/ready    register index, write data
//
//  Each slot takes one divider pass for the percent (none when full_mv is
//  not above empty_mv); an early update adds a scaling pass, and the last
//  slot of a window with valid readings adds an average and a scaling pass.
//  The single shared divider runs one pass at a time: a start step, then
//  23 quotient bits.
//  Reset (rst, synchronous) clears the window, the stored voltage and the
//  mismatch flag, and loads the register defaults. Two slots queue up in
//  front of the sequencer while a result waits in the output register.
//
module battery_voltage_monitor (
  input  logic         clk,
  input  logic         rst,
  bvm_sample_if.sink   samples,
  bvm_result_if.source results,
  bvm_cfg_if.sink      cfg
);

  bvm_pkg::cfg_t     regs;
  logic              q_full;
  logic              q_empty;
  logic              push;
  logic              pop;
  bvm_pkg::cmd_t     push_cmd;
  bvm_pkg::cmd_t     head;
  bvm_pkg::div_req_t div_req;
  bvm_pkg::div_rsp_t div_rsp;

  // Configuration: always ready; an index past the list is dropped.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.div_top     <= bvm_pkg::RST_DIV_TOP;
      regs.div_bottom  <= bvm_pkg::RST_DIV_BOTTOM;
      regs.plaus_min   <= bvm_pkg::RST_PLAUS_MIN;
      regs.plaus_max   <= bvm_pkg::RST_PLAUS_MAX;
      regs.critical_mv <= bvm_pkg::RST_CRITICAL;
      regs.full_mv     <= bvm_pkg::RST_FULL;
      regs.empty_mv    <= bvm_pkg::RST_EMPTY;
    end else if (cfg.valid) begin
      case (cfg.index)
        bvm_pkg::REG_DIV_TOP:    regs.div_top     <= cfg.data[bvm_pkg::KOHM_W-1:0];
        bvm_pkg::REG_DIV_BOTTOM: regs.div_bottom  <= cfg.data[bvm_pkg::KOHM_W-1:0];
        bvm_pkg::REG_PLAUS_MIN:  regs.plaus_min   <= cfg.data;
        bvm_pkg::REG_PLAUS_MAX:  regs.plaus_max   <= cfg.data;
        bvm_pkg::REG_CRITICAL:   regs.critical_mv <= cfg.data;
        bvm_pkg::REG_FULL:       regs.full_mv     <= cfg.data;
        bvm_pkg::REG_EMPTY:      regs.empty_mv    <= cfg.data;
        default: begin
          regs <= regs;
        end
      endcase
    end
  end

  // Front: accumulate the window and classify each slot.
  bvm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .samples  (samples),
    .full     (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Queue: hold classified slots while the sequencer is busy.
  bvm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (head)
  );

  // Divider shared by the average, the scaling and the percent.
  bvm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Back: run the arithmetic and drive the result register.
  bvm_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (regs),
    .q_empty (q_empty),
    .head    (head),
    .pop     (pop),
    .div_req (div_req),
    .div_rsp (div_rsp),
    .results (results)
  );

endmodule
